// ===== hw/rtl/asc_pkg.sv =====
// Package of the activation statistics counter: item types, function codes,
// command format between the front and back parts, and default sizes. No dependencies.
`default_nettype none
package asc_pkg;

   localparam int NEURONS_DEFAULT  = 1024;
   localparam int VARIANTS_DEFAULT = 8;
   localparam int QUEUE_DEPTH      = 4;
   localparam int COUNT_WIDTH      = 64;
   localparam int LEVEL_WIDTH      = 15;

   localparam logic [LEVEL_WIDTH-1:0] LEVEL_RESET = 15'd255;

   localparam logic [1:0] FUNC_SAMPLE = 2'd0;
   localparam logic [1:0] FUNC_READ   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic               perspective;
      logic [9:0]         neuron_index;
      logic signed [15:0] accum_value;
      logic [2:0]         variant;
      logic               position_end;
   } req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] active_count;
      logic [COUNT_WIDTH-1:0] saturated_count;
      logic [COUNT_WIDTH-1:0] clamped_sum;
      logic [COUNT_WIDTH-1:0] positions_seen;
      logic [COUNT_WIDTH-1:0] variant_uses;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_SAMPLE,
      OP_READ,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   perspective;
      logic [9:0]             neuron_index;
      logic                   neuron_ok;
      logic [2:0]             variant;
      logic                   variant_ok;
      logic                   active_inc;
      logic                   saturated_inc;
      logic [LEVEL_WIDTH-1:0] clamped;
      logic                   position_end;
   } cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/asc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module asc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/asc_front.sv =====
// Front part: holds the saturation level register and turns each accepted item
// into a command for the back part. Depends on asc_pkg.
`default_nettype none
module asc_front #(
   parameter int NEURONS  = asc_pkg::NEURONS_DEFAULT,
   parameter int VARIANTS = asc_pkg::VARIANTS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [asc_pkg::LEVEL_WIDTH-1:0]     csr_data,
   input  wire asc_pkg::req_type                    req,
   output logic                                     cmd_valid,
   output asc_pkg::cmd_type                         cmd
);

   logic [asc_pkg::LEVEL_WIDTH-1:0] level_ff;
   logic [asc_pkg::LEVEL_WIDTH-1:0] level_in;
   logic signed [15:0]              level_s;

   assign csr_ready = 1'b1;

   always_comb begin
      level_in = level_ff;
      if (csr_valid) begin
         level_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= asc_pkg::LEVEL_RESET;
      end else begin
         level_ff <= level_in;
      end
   end

   assign level_s = $signed({1'b0, level_ff});

   always_comb begin
      cmd_valid          = 1'b1;
      cmd.op             = asc_pkg::OP_SAMPLE;
      unique case (req.func)
         asc_pkg::FUNC_SAMPLE: cmd.op = asc_pkg::OP_SAMPLE;
         asc_pkg::FUNC_READ:   cmd.op = asc_pkg::OP_READ;
         asc_pkg::FUNC_CLEAR:  cmd.op = asc_pkg::OP_CLEAR;
         default:              cmd_valid = 1'b0;
      endcase
      cmd.perspective    = req.perspective;
      cmd.neuron_index   = req.neuron_index;
      cmd.neuron_ok      = int'(req.neuron_index) < NEURONS;
      cmd.variant        = req.variant;
      cmd.variant_ok     = int'(req.variant) < VARIANTS;
      cmd.active_inc     = req.accum_value > 16'sd0;
      cmd.saturated_inc  = req.accum_value >= level_s;
      if (req.accum_value < 16'sd0) begin
         cmd.clamped = '0;
      end else if (req.accum_value > level_s) begin
         cmd.clamped = level_ff;
      end else begin
         cmd.clamped = req.accum_value[asc_pkg::LEVEL_WIDTH-1:0];
      end
      cmd.position_end   = req.position_end;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asc_queue.sv =====
// Short command queue between the front and back parts.
// Depends on asc_pkg.
`default_nettype none
module asc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_en,
   input  wire asc_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop_en,
   output logic                  head_valid,
   output asc_pkg::cmd_type      head_data
);

   localparam int PW = $clog2(asc_pkg::QUEUE_DEPTH);

   asc_pkg::cmd_type mem_ff [asc_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;

   assign full       = int'(count_ff) == asc_pkg::QUEUE_DEPTH;
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_en) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_en) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         count_in = count_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/asc_back.sv =====
// Back part: read-modify-write of the counter memories, the clearing pass and
// the result register. Depends on asc_pkg and asc_ram.
`default_nettype none
module asc_back #(
   parameter int NEURONS  = asc_pkg::NEURONS_DEFAULT,
   parameter int VARIANTS = asc_pkg::VARIANTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire asc_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   output logic                  init_busy,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output asc_pkg::rsp_type      rsp_data
);

   localparam int SLOTS   = 2 * NEURONS;
   localparam int SW      = $clog2(SLOTS);
   localparam int VW      = VARIANTS > 1 ? $clog2(VARIANTS) : 1;
   localparam int CLR_LEN = SLOTS > VARIANTS ? SLOTS : VARIANTS;
   localparam int CW      = $clog2(CLR_LEN);
   localparam int CWIDTH  = asc_pkg::COUNT_WIDTH;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } state_type;

   state_type            state_ff;
   logic                 init_ff;
   logic [CW-1:0]        cnt_ff;
   asc_pkg::cmd_type     cur_ff;
   logic [SW-1:0]        cur_slot_ff;
   logic [VW-1:0]        cur_vidx_ff;
   logic [CWIDTH-1:0]    positions_ff;
   logic                 out_valid_ff;
   asc_pkg::rsp_type     out_ff;

   logic [SW-1:0]        head_slot;
   logic [VW-1:0]        head_vidx;
   logic [VW+2:0]        head_var_wide;
   logic                 rd_en;
   logic                 slot_wr_en;
   logic [SW-1:0]        slot_wr_addr;
   logic [CWIDTH-1:0]    act_wr, sat_wr, sum_wr;
   logic [CWIDTH-1:0]    act_rd, sat_rd, sum_rd;
   logic                 var_wr_en;
   logic [VW-1:0]        var_wr_addr;
   logic [CWIDTH-1:0]    var_wr, var_rd;
   logic                 out_free;
   logic                 out_load;

   assign head_slot     = cmd.perspective ? SW'(NEURONS + int'(cmd.neuron_index))
                                          : SW'(int'(cmd.neuron_index));
   assign head_var_wide = (VW+3)'(cmd.variant);
   assign head_vidx     = head_var_wide[VW-1:0];
   assign cmd_pop       = state_ff == ST_IDLE && cmd_valid;
   assign rd_en         = cmd_pop;
   assign out_free      = !out_valid_ff || rsp_pop;
   assign out_load      = state_ff == ST_UPDATE && cur_ff.op != asc_pkg::OP_SAMPLE && out_free;
   assign init_busy     = init_ff;
   assign rsp_empty     = !out_valid_ff;
   assign rsp_data      = out_ff;

   always_comb begin
      slot_wr_en   = 1'b0;
      slot_wr_addr = cur_slot_ff;
      act_wr       = act_rd + CWIDTH'(cur_ff.active_inc);
      sat_wr       = sat_rd + CWIDTH'(cur_ff.saturated_inc);
      sum_wr       = sum_rd + CWIDTH'(cur_ff.clamped);
      var_wr_en    = 1'b0;
      var_wr_addr  = cur_vidx_ff;
      var_wr       = var_rd + 1'b1;
      unique case (state_ff)
         ST_CLEAR: begin
            slot_wr_en   = int'(cnt_ff) < SLOTS;
            slot_wr_addr = cnt_ff[SW-1:0];
            act_wr       = '0;
            sat_wr       = '0;
            sum_wr       = '0;
            var_wr_en    = int'(cnt_ff) < VARIANTS;
            var_wr_addr  = cnt_ff[VW-1:0];
            var_wr       = '0;
         end
         ST_UPDATE: begin
            if (cur_ff.op == asc_pkg::OP_SAMPLE) begin
               slot_wr_en = cur_ff.neuron_ok;
               var_wr_en  = cur_ff.position_end && cur_ff.variant_ok;
            end
         end
         default: begin
         end
      endcase
   end

   asc_ram #(.WIDTH(CWIDTH), .DEPTH(SLOTS)) u_active (
      .clock(clock), .wr_en(slot_wr_en), .wr_addr(slot_wr_addr), .wr_data(act_wr),
      .rd_en(rd_en), .rd_addr(head_slot), .rd_data(act_rd)
   );

   asc_ram #(.WIDTH(CWIDTH), .DEPTH(SLOTS)) u_saturated (
      .clock(clock), .wr_en(slot_wr_en), .wr_addr(slot_wr_addr), .wr_data(sat_wr),
      .rd_en(rd_en), .rd_addr(head_slot), .rd_data(sat_rd)
   );

   asc_ram #(.WIDTH(CWIDTH), .DEPTH(SLOTS)) u_sum (
      .clock(clock), .wr_en(slot_wr_en), .wr_addr(slot_wr_addr), .wr_data(sum_wr),
      .rd_en(rd_en), .rd_addr(head_slot), .rd_data(sum_rd)
   );

   asc_ram #(.WIDTH(CWIDTH), .DEPTH(VARIANTS)) u_variant (
      .clock(clock), .wr_en(var_wr_en), .wr_addr(var_wr_addr), .wr_data(var_wr),
      .rd_en(rd_en), .rd_addr(head_vidx), .rd_data(var_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         init_ff      <= 1'b1;
         cnt_ff       <= '0;
         positions_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (int'(cnt_ff) == CLR_LEN - 1) begin
                  state_ff <= ST_IDLE;
                  init_ff  <= 1'b0;
               end
            end
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff      <= cmd;
                  cur_slot_ff <= head_slot;
                  cur_vidx_ff <= head_vidx;
                  if (cmd.op == asc_pkg::OP_CLEAR) begin
                     state_ff     <= ST_CLEAR;
                     cnt_ff       <= '0;
                     positions_ff <= '0;
                  end else begin
                     state_ff <= ST_UPDATE;
                  end
               end
            end
            ST_UPDATE: begin
               if (cur_ff.op == asc_pkg::OP_SAMPLE) begin
                  if (cur_ff.position_end) begin
                     positions_ff <= positions_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end else if (out_free) begin
                  out_ff.active_count    <= cur_ff.neuron_ok ? act_rd : '0;
                  out_ff.saturated_count <= cur_ff.neuron_ok ? sat_rd : '0;
                  out_ff.clamped_sum     <= cur_ff.neuron_ok ? sum_rd : '0;
                  out_ff.positions_seen  <= positions_ff;
                  out_ff.variant_uses    <= cur_ff.variant_ok ? var_rd : '0;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/activation_stats_counter.sv =====
// Top level of the activation statistics counter: front, command queue and back.
// Depends on asc_pkg, asc_front, asc_queue and asc_back.
//
// Items enter through push/full/req_data; an item is taken at a clock edge with
// push high and full low. Func code 3 is taken and dropped. Read results leave
// through empty/pop/rsp_data; the oldest result shows while empty is low and is
// taken at an edge with pop high. The saturation level is written through
// csr_valid/csr_data, which is always ready; the user must write it only while
// no item is in flight, as the block itself does not enforce this. A taken item
// waits in a four-entry queue; the back part handles a sample or a read as a
// memory read, then an add and write back, and takes a new item only after it
// has finished the last one. A clear item sweeps the counter memories one entry
// per cycle, max(2*NEURONS, VARIANTS) entries (2048 at the defaults), while
// further items still queue up. After reset the same sweep runs and full stays
// high until it ends. When the receiver stalls with a result waiting, the back
// part holds the next read and the queue fills.
`default_nettype none
module activation_stats_counter #(
   parameter int NEURONS  = asc_pkg::NEURONS_DEFAULT,
   parameter int VARIANTS = asc_pkg::VARIANTS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire asc_pkg::req_type                req_data,
   output logic                                 empty,
   input  wire logic                            pop,
   output asc_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [asc_pkg::LEVEL_WIDTH-1:0] csr_data
);

   asc_pkg::cmd_type front_cmd;
   asc_pkg::cmd_type head_cmd;
   logic             front_valid;
   logic             queue_full;
   logic             head_valid;
   logic             head_pop;
   logic             init_busy;

   assign full = queue_full || init_busy;

   asc_front #(.NEURONS(NEURONS), .VARIANTS(VARIANTS)) u_front (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req(req_data), .cmd_valid(front_valid), .cmd(front_cmd)
   );

   asc_queue u_queue (
      .clock(clock), .reset(reset),
      .push_en(push && !full && front_valid), .push_data(front_cmd), .full(queue_full),
      .pop_en(head_pop), .head_valid(head_valid), .head_data(head_cmd)
   );

   asc_back #(.NEURONS(NEURONS), .VARIANTS(VARIANTS)) u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(head_valid), .cmd(head_cmd), .cmd_pop(head_pop),
      .init_busy(init_busy),
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/asc_checker.sv =====
// Port-level assertions for the activation statistics counter, bound to the top level.
// Depends on asc_pkg and activation_stats_counter.
`default_nettype none
module asc_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            full,
   input wire logic                            empty,
   input wire logic                            pop,
   input wire asc_pkg::rsp_type                rsp_data,
   input wire logic                            csr_valid,
   input wire logic                            csr_ready
);

   a_reset_full : assert property (@(posedge clock) reset |=> full)
      else $error("input side open right after reset");

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("result shown right after reset");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed or vanished");

   a_csr_ready : assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind activation_stats_counter asc_checker u_asc_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty), .pop(pop),
   .rsp_data(rsp_data), .csr_valid(csr_valid), .csr_ready(csr_ready)
);
`default_nettype wire

// ===== dv/activation_stats_counter_checker.sv =====
// Scoreboard for the activation statistics counter: it watches the item, result and
// register channels, predicts every read and compares each result field by field.
// Depends on asc_pkg.
module activation_stats_counter_checker
   import asc_pkg::*;
#(
   parameter int NEURONS  = NEURONS_DEFAULT,
   parameter int VARIANTS = VARIANTS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   full,
   input  req_type                req_data,
   input  logic                   empty,
   input  logic                   pop,
   input  rsp_type                rsp_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [LEVEL_WIDTH-1:0] csr_data,
   output int                     mismatches,
   output int                     waiting,
   output int                     checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [COUNT_WIDTH-1:0] active_tally    [2*NEURONS];
   logic [COUNT_WIDTH-1:0] saturated_tally [2*NEURONS];
   logic [COUNT_WIDTH-1:0] level_tally     [2*NEURONS];
   logic [COUNT_WIDTH-1:0] variant_tally   [VARIANTS];
   logic [COUNT_WIDTH-1:0] position_tally;
   logic [LEVEL_WIDTH-1:0] level_now;
   rsp_type                pending_reads[$];

   function automatic void wipe_counts();
      for (int i = 0; i < 2*NEURONS; i++) begin
         active_tally[i]    = '0;
         saturated_tally[i] = '0;
         level_tally[i]     = '0;
      end
      for (int i = 0; i < VARIANTS; i++) begin
         variant_tally[i] = '0;
      end
      position_tally = '0;
   endfunction

   task automatic report_mismatch(input string what, input logic [COUNT_WIDTH-1:0] got,
                                  input logic [COUNT_WIDTH-1:0] want);
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic void apply_item(input req_type it);
      int      value;
      int      lvl;
      int      clip;
      int      slot;
      logic    in_range;
      logic    variant_ok;
      rsp_type want;
      value      = int'($signed(it.accum_value));
      lvl        = int'(level_now);
      in_range   = int'(it.neuron_index) < NEURONS;
      variant_ok = int'(it.variant) < VARIANTS;
      slot       = int'(it.perspective) * NEURONS + int'(it.neuron_index);
      case (it.func)
         FUNC_SAMPLE: begin
            if (in_range) begin
               clip = (value < 0) ? 0 : ((value > lvl) ? lvl : value);
               if (value > 0) active_tally[slot] += 1;
               if (value >= lvl) saturated_tally[slot] += 1;
               level_tally[slot] += COUNT_WIDTH'(clip);
            end
            if (it.position_end) begin
               position_tally += 1;
               if (variant_ok) variant_tally[it.variant] += 1;
            end
         end
         FUNC_READ: begin
            want.active_count    = in_range ? active_tally[slot] : '0;
            want.saturated_count = in_range ? saturated_tally[slot] : '0;
            want.clamped_sum     = in_range ? level_tally[slot] : '0;
            want.positions_seen  = position_tally;
            want.variant_uses    = variant_ok ? variant_tally[it.variant] : '0;
            pending_reads = {pending_reads, want};
         end
         FUNC_CLEAR: begin
            wipe_counts();
         end
         default: begin
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         wipe_counts();
         level_now = LEVEL_RESET;
         pending_reads.delete();
      end else begin
         if (csr_valid && csr_ready) level_now = csr_data;
         if (pop && !empty) begin
            if (pending_reads.size() == 0) begin
               report_mismatch("result with no read pending", rsp_data.active_count, '0);
            end else begin
               want = pending_reads.pop_front();
               if (rsp_data.active_count !== want.active_count)
                  report_mismatch("active_count", rsp_data.active_count, want.active_count);
               if (rsp_data.saturated_count !== want.saturated_count)
                  report_mismatch("saturated_count", rsp_data.saturated_count,
                                  want.saturated_count);
               if (rsp_data.clamped_sum !== want.clamped_sum)
                  report_mismatch("clamped_sum", rsp_data.clamped_sum, want.clamped_sum);
               if (rsp_data.positions_seen !== want.positions_seen)
                  report_mismatch("positions_seen", rsp_data.positions_seen,
                                  want.positions_seen);
               if (rsp_data.variant_uses !== want.variant_uses)
                  report_mismatch("variant_uses", rsp_data.variant_uses, want.variant_uses);
               checked++;
            end
         end
         if (push && !full) apply_item(req_data);
      end
      waiting = pending_reads.size();
   end

endmodule

// ===== dv/activation_stats_counter_tb.sv =====
// Top of the activation statistics counter testbench: clock, reset, item and register
// stimulus, receiver stalls, watchdog and verdict. Depends on asc_pkg, the block and
// activation_stats_counter_checker.
module activation_stats_counter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import asc_pkg::*;

   localparam logic [1:0] FUNC_UNUSED    = 2'd3;
   localparam int         LONG_HOLD      = 300;
   localparam int         WATCHDOG_LIMIT = 50000;
   localparam int         PHASE_ITEMS    = 115;
   localparam int         SETTLE         = 32;
   localparam logic [9:0] HOT_NEURONS [6] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd511, 10'd1023};

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   push      = 1'b0;
   logic                   full;
   req_type                req_data  = '0;
   logic                   empty;
   logic                   pop       = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [LEVEL_WIDTH-1:0] csr_data  = '0;

   int   mismatch_count;
   int   expected_left;
   int   results_checked;
   int   quiet_cycles   = 0;
   int   holds_asked    = 0;
   int   holds_done     = 0;
   int   cur_level      = int'(LEVEL_RESET);
   int   items_sent     = 0;
   int   samples_sent   = 0;
   int   reads_sent     = 0;
   int   clears_sent    = 0;
   int   unused_sent    = 0;
   int   levels_written = 0;
   int   clears_since_fence = 1;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   activation_stats_counter DUT (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   activation_stats_counter_checker stats_check (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatch_count),
      .waiting    (expected_left),
      .checked    (results_checked)
   );

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("Watchdog: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin : receiver
      int stall_pct;
      int rx_cycle;
      stall_pct = 0;
      rx_cycle  = 0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         case ((rx_cycle / 64) % 4)
            0: stall_pct = 0;
            1: stall_pct = 30;
            2: stall_pct = 70;
            default: stall_pct = 10;
         endcase
         if (holds_asked != holds_done) begin
            pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else begin
            pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   function automatic req_type build(input logic [1:0] f, input logic p, input logic [9:0] n,
                                     input logic [15:0] v, input logic [2:0] vr,
                                     input logic pe);
      req_type it;
      it.func         = f;
      it.perspective  = p;
      it.neuron_index = n;
      it.accum_value  = v;
      it.variant      = vr;
      it.position_end = pe;
      return it;
   endfunction

   function automatic logic [9:0] pick_neuron();
      int r;
      r = $urandom_range(0, 9);
      return (r < 6) ? HOT_NEURONS[r] : 10'($urandom_range(0, 1023));
   endfunction

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'(cur_level);
         4: return 16'(cur_level - 1);
         5: return 16'(cur_level + 1);
         6, 7: return 16'($urandom_range(0, cur_level + 16));
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic offer(input req_type it);
      req_data <= it;
      push     <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      case (it.func)
         FUNC_SAMPLE: samples_sent++;
         FUNC_READ:   reads_sent++;
         FUNC_CLEAR: begin
            clears_sent++;
            clears_since_fence++;
         end
         default: unused_sent++;
      endcase
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         push <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_and_settle();
      push <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (clears_since_fence * (2*NEURONS_DEFAULT + SETTLE) + SETTLE) @(posedge clock);
      clears_since_fence = 0;
   endtask

   task automatic write_level(input logic [LEVEL_WIDTH-1:0] lvl);
      drain_and_settle();
      csr_data  <= lvl;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_level = int'(lvl);
      levels_written++;
   endtask

   // One position: samples that mostly share a variant, the last one closing the position, with
   // reads, clears, unused codes and malformed position marks mixed in.
   task automatic run_position(input int read_pct);
      int         len;
      int         roll;
      logic [2:0] var_sel;
      req_type    it;
      len     = $urandom_range(1, 12);
      var_sel = 3'($urandom_range(0, 7));
      for (int i = 0; i < len; i++) begin
         roll = $urandom_range(0, 999);
         it = build(FUNC_SAMPLE, 1'($urandom_range(0, 1)), pick_neuron(), pick_value(),
                    var_sel, i == len - 1);
         if (roll < 5) begin
            it.func         = FUNC_CLEAR;
            it.position_end = 1'($urandom_range(0, 1));
         end else if (roll < 30) begin
            it.func         = FUNC_UNUSED;
            it.position_end = 1'($urandom_range(0, 1));
         end else if (roll < 30 + read_pct * 10) begin
            it.func         = FUNC_READ;
            it.variant      = 3'($urandom_range(0, 7));
            it.position_end = 1'($urandom_range(0, 1));
         end else if (roll < 80 + read_pct * 10) begin
            it.variant      = 3'($urandom_range(0, 7));
            it.position_end = 1'($urandom_range(0, 1));
         end
         offer(it);
         if ($urandom_range(0, 9) == 0) pause_sender($urandom_range(1, 3));
      end
      case ($urandom_range(0, 9))
         4, 5, 6, 7: pause_sender($urandom_range(1, 4));
         8: pause_sender($urandom_range(5, 15));
         default: ;
      endcase
   endtask

   initial begin : stimulus
      int phase_start;
      logic [LEVEL_WIDTH-1:0] lvl;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed items at the reset saturation level.
      offer(build(FUNC_SAMPLE, 1'b0, 10'd0, 16'h7FFF, 3'd0, 1'b0));
      offer(build(FUNC_SAMPLE, 1'b0, 10'd0, 16'h8000, 3'd0, 1'b0));
      offer(build(FUNC_SAMPLE, 1'b0, 10'd0, 16'd0, 3'd0, 1'b0));
      offer(build(FUNC_SAMPLE, 1'b0, 10'd0, 16'd255, 3'd0, 1'b0));
      offer(build(FUNC_SAMPLE, 1'b0, 10'd0, 16'd254, 3'd0, 1'b0));
      offer(build(FUNC_SAMPLE, 1'b0, 10'd0, 16'd256, 3'd0, 1'b1));
      offer(build(FUNC_SAMPLE, 1'b1, 10'd1023, 16'd1, 3'd7, 1'b1));
      offer(build(FUNC_READ, 1'b0, 10'd0, 16'd0, 3'd0, 1'b0));
      offer(build(FUNC_READ, 1'b1, 10'd1023, 16'hFFFF, 3'd7, 1'b0));
      offer(build(FUNC_READ, 1'b1, 10'd0, 16'd0, 3'd3, 1'b1));
      offer(build(FUNC_UNUSED, 1'b1, 10'd1023, 16'hFFFF, 3'd7, 1'b1));
      offer(build(FUNC_READ, 1'b0, 10'd0, 16'd0, 3'd7, 1'b1));
      offer(build(FUNC_CLEAR, 1'b0, 10'd0, 16'd0, 3'd5, 1'b1));
      offer(build(FUNC_READ, 1'b0, 10'd0, 16'd0, 3'd0, 1'b0));
      offer(build(FUNC_READ, 1'b1, 10'd1023, 16'd0, 3'd7, 1'b0));
      offer(build(FUNC_SAMPLE, 1'b1, 10'd512, 16'hFFFF, 3'd3, 1'b1));
      offer(build(FUNC_READ, 1'b1, 10'd512, 16'd0, 3'd3, 1'b0));

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: lvl = '0;
            1: lvl = '1;
            2: lvl = LEVEL_WIDTH'($urandom_range(2, 32766));
            3: lvl = 15'd1;
            default: lvl = LEVEL_RESET;
         endcase
         write_level(lvl);
         if (ph == 2 || ph == 4) holds_asked++;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            run_position((ph == 2 || ph == 4) ? 60 : 20);
         end
      end

      push <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("Sent %0d items: %0d samples, %0d reads, %0d clears, %0d unused codes.",
               items_sent, samples_sent, reads_sent, clears_sent, unused_sent);
      $display("Checked %0d read results across %0d saturation level writes and %0d long holds.",
               results_checked, levels_written, holds_done);
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
